### hdl/assert_macros.svh
// Assertion macros for the RTL of the median baseline drop detector.
// No dependencies; simulation builds get the checks, synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define MBDD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("property violated");

// A condition that must never be true outside reset.
`define MBDD_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define MBDD_ASSERT(lbl, clk, rstn, prop)
`define MBDD_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### hdl/mbdd_pkg.sv
// Types and fixed constants of the median baseline drop detector.
// No dependencies; imported by median_baseline_drop_detector and its bench.
package mbdd_pkg;

    localparam int MARGIN_W   = 7;
    localparam int DISCARD_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 7'd10;
    localparam logic [DISCARD_W-1:0] DISCARD_RST = 8'd8;

    // Percentage scale of the margin register.
    localparam int PCT_SCALE = 100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_END,
        S_MED,
        S_DET,
        S_DONE
    } t_state;

endpackage

### hdl/median_baseline_drop_detector.sv
// Median baseline drop detector: top level, holding the sorted calibration memory.
// Depends on mbdd_pkg and assert_macros.svh.
//
// One result item is returned for every sample item. While discarding, an item
// goes straight to the output register; after calibration an item passes through
// the product register, the compare and the output register. During collection
// each sample is inserted into a sorted single-port-read, single-port-write
// memory of CAL_COUNT entries, one entry shifted per cycle for every stored
// sample larger than it; the item that fills the memory then reads back the
// median. A new item is accepted only while the block is idle, but the
// finished result sits in an output register, so the next item may be taken
// while that result is still waiting.
`include "assert_macros.svh"

module median_baseline_drop_detector
    import mbdd_pkg::*;
#(
    parameter int CAL_COUNT   = 101,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_detected,
    output logic                   o_calibrated,
    output logic [SAMPLE_BITS-1:0] o_baseline,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(CAL_COUNT);
    localparam int CNT_W  = $clog2(CAL_COUNT + 1);
    localparam int PROD_W = SAMPLE_BITS + MARGIN_W;
    localparam int MID    = CAL_COUNT / 2;

    t_state                 r_state, n_state;

    logic [MARGIN_W-1:0]    r_margin;
    logic [DISCARD_W-1:0]   r_discard;
    logic [DISCARD_W-1:0]   r_disc_cnt;
    logic                   r_collect;
    logic [CNT_W-1:0]       r_fill;
    logic                   r_calib;
    logic [SAMPLE_BITS-1:0] r_median;

    logic [SAMPLE_BITS-1:0] r_samp;
    logic [PROD_W-1:0]      r_prod;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_res_det;

    logic                   r_out_valid;
    logic                   r_out_det;
    logic                   r_out_cal;
    logic [SAMPLE_BITS-1:0] r_out_base;

    logic [SAMPLE_BITS-1:0] r_store [CAL_COUNT];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;

    logic                   in_acc;
    logic                   out_free;
    logic                   discard_now;
    logic                   shift;
    logic [CNT_W-1:0]       fill_inc;
    logic [SAMPLE_BITS:0]   diff;
    logic                   det;

    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign discard_now = !r_collect && (r_disc_cnt < r_discard);
    assign shift       = (r_rd_data > r_samp);
    assign fill_inc    = r_fill + CNT_W'(1);

    // Sample below baseline - floor(baseline*margin/100) is the same as
    // baseline*margin < 100*(baseline - sample) with a positive difference.
    assign diff = {1'b0, r_median} - {1'b0, r_samp};
    assign det  = !diff[SAMPLE_BITS] && (diff != '0) &&
                  (r_prod < PROD_W'(diff[SAMPLE_BITS-1:0]) * PROD_W'(PCT_SCALE));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_calib) begin
                        n_state = S_DET;
                    end else if (discard_now) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                n_state = (r_idx == '0) ? S_INS_END : S_INS_CMP;
            end
            S_INS_CMP: begin
                if (!shift) begin
                    n_state = S_INS_END;
                end else if (r_idx == ADDR_W'(1)) begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_END: begin
                n_state = (fill_inc >= CNT_W'(CAL_COUNT)) ? S_MED : S_DONE;
            end
            S_MED:  n_state = S_DONE;
            S_DET:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: handshake and memory port controls
    always_comb begin
        o_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx - ADDR_W'(1);
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_samp;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_INS_RD: begin
                if (r_idx == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (shift) begin
                    wr_data = r_rd_data;
                    // Fetch the next lower neighbour while this one moves up.
                    rd_en   = (r_idx != ADDR_W'(1));
                    rd_addr = r_idx - ADDR_W'(2);
                end
            end
            S_INS_END: begin
                rd_en   = (fill_inc >= CNT_W'(CAL_COUNT));
                rd_addr = ADDR_W'(MID);
            end
            S_MED, S_DET, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Calibration memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin  <= MARGIN_RST;
            r_discard <= DISCARD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MARGIN:  r_margin  <= i_cfg_data[MARGIN_W-1:0];
                CFG_DISCARD: r_discard <= i_cfg_data[DISCARD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_disc_cnt  <= '0;
            r_collect   <= 1'b0;
            r_fill      <= '0;
            r_calib     <= 1'b0;
            r_median    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && in_acc && !r_calib) begin
                if (discard_now) begin
                    r_disc_cnt <= r_disc_cnt + DISCARD_W'(1);
                end else begin
                    r_collect <= 1'b1;
                end
            end
            if (r_state == S_INS_END) begin
                r_fill <= fill_inc;
            end
            if (r_state == S_MED) begin
                r_median <= r_rd_data;
                r_calib  <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_samp    <= i_sample;
            r_prod    <= PROD_W'(r_median) * PROD_W'(r_margin);
            r_idx     <= r_fill[ADDR_W-1:0];
            r_res_det <= 1'b0;
        end
        if (r_state == S_INS_CMP && shift) begin
            r_idx <= r_idx - ADDR_W'(1);
        end
        if (r_state == S_DET) begin
            r_res_det <= det;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_det  <= r_res_det;
            r_out_cal  <= r_calib;
            r_out_base <= r_calib ? r_median : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_detected   = r_out_det;
    assign o_calibrated = r_out_cal;
    assign o_baseline   = r_out_base;

    `MBDD_ASSERT_NEVER(a_rw_same_entry, i_clk, i_rst_n, rd_en && wr_en && (rd_addr == wr_addr))
    `MBDD_ASSERT(a_fill_bound, i_clk, i_rst_n, r_calib || (r_state == S_MED) || (r_fill < CNT_W'(CAL_COUNT)))
    `MBDD_ASSERT(a_calib_from_median, i_clk, i_rst_n, $rose(r_calib) |-> $past(r_state == S_MED))
    `MBDD_ASSERT(a_det_needs_cal, i_clk, i_rst_n, (r_out_valid && r_out_det) |-> r_out_cal)

endmodule

### verif/median_baseline_drop_detector_tb.sv
// Self-checking bench for median_baseline_drop_detector: a directed plan, then calibration and
// detection traffic with random stalls on both channels, predicted by an in-bench detector model.
// Depends on mbdd_pkg and the RTL of the block; needs no files or arguments.
module median_baseline_drop_detector_tb
    import mbdd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAL_COUNT      = 101;
    localparam int SAMPLE_BITS    = 10;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 2;
    localparam int TAIL_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_EVERY     = 300;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 100;
    localparam int DIRECTED_ROWS  = 14;

    typedef struct packed {
        logic                   detected;
        logic                   calibrated;
        logic [SAMPLE_BITS-1:0] baseline;
    } t_verdict;

    localparam t_verdict NOT_CALIBRATED = '0;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SAMPLE_BITS-1:0] value;
        logic                   typed;
        t_verdict               want;
    } t_plan_row;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample     = '0;
    logic                   o_valid;
    logic                   i_ready      = 1'b0;
    logic                   o_detected;
    logic                   o_calibrated;
    logic [SAMPLE_BITS-1:0] o_baseline;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx    = CFG_MARGIN;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;

    // Detector model state, mirrored from the block.
    logic [MARGIN_W-1:0]    margin_q    = MARGIN_RST;
    logic [DISCARD_W-1:0]   disc_q      = DISCARD_RST;
    logic [8:0]             phase_cnt   = '0;
    logic [SAMPLE_BITS-1:0] calib_sorted [CAL_COUNT];
    logic [SAMPLE_BITS-1:0] median_q    = '0;
    logic                   calib_done  = 1'b0;

    t_verdict pending_verdicts [$];

    int  items_sent   = 0;
    int  calib_items  = 0;
    int  results_seen = 0;
    int  drops_seen   = 0;
    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  rx_hold      = 0;
    bit  rx_calm      = 1'b0;
    bit  tx_calm      = 1'b0;

    // Before calibration every item must come back all zero, so those rows carry their result.
    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        '{ROW_WRITE,  CFG_DISCARD, 10'd255,  1'b0, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd0,    1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd1023, 1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'h155,  1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'h2AA,  1'b1, NOT_CALIBRATED},
        '{ROW_WRITE,  CFG_MARGIN,  10'd0,    1'b0, NOT_CALIBRATED},
        '{ROW_WRITE,  CFG_DISCARD, 10'd0,    1'b0, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd1023, 1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd0,    1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd1023, 1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd0,    1'b1, NOT_CALIBRATED},
        '{ROW_WRITE,  CFG_MARGIN,  10'd100,  1'b0, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd511,  1'b1, NOT_CALIBRATED},
        '{ROW_SAMPLE, CFG_MARGIN,  10'd512,  1'b1, NOT_CALIBRATED}
    };

    median_baseline_drop_detector #(
        .CAL_COUNT   (CAL_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_detected   (o_detected),
        .o_calibrated (o_calibrated),
        .o_baseline   (o_baseline),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Level below which a calibrated sample counts as a drop; can go negative once the margin passes 100%.
    function automatic int drop_level();
        return int'(median_q) - (int'(median_q) * int'(margin_q)) / PCT_SCALE;
    endfunction

    function automatic t_verdict step_detector(input logic [SAMPLE_BITS-1:0] value);
        t_verdict   res;
        logic [7:0] low;
        int         fill;
        int         slot;
        res = '0;
        low = phase_cnt[7:0];
        if (calib_done) begin
            res.detected = (int'(value) < drop_level());
        end else if (!phase_cnt[8] && low < disc_q) begin
            phase_cnt = {1'b0, low + 8'd1};
        end else begin
            fill = phase_cnt[8] ? int'(low) : 0;
            slot = fill;
            while (slot > 0 && calib_sorted[slot-1] > value) begin
                calib_sorted[slot] = calib_sorted[slot-1];
                slot--;
            end
            calib_sorted[slot] = value;
            fill++;
            phase_cnt = {1'b1, fill[7:0]};
            if (fill >= CAL_COUNT) begin
                median_q   = calib_sorted[CAL_COUNT/2];
                calib_done = 1'b1;
            end
        end
        res.calibrated = calib_done;
        res.baseline   = calib_done ? median_q : '0;
        return res;
    endfunction

    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] value, input logic typed,
                                input t_verdict want);
        t_verdict calc;
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!calib_done) calib_items++;
        calc = step_detector(value);
        pending_verdicts.push_back(typed ? want : calc);
        items_sent++;
    endtask

    task automatic sender_pause();
        int gap;
        int pick;
        gap = 0;
        if (!tx_calm) begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                gap = $urandom_range(15, 60);
            else if (pick >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Registers change only with the block idle: every result back, then a short pause.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MARGIN)
            margin_q = data[MARGIN_W-1:0];
        else
            disc_q = data;
        @(posedge i_clk);
    endtask

    task automatic check_result();
        t_verdict want;
        results_seen++;
        if (o_detected) drops_seen++;
        if (pending_verdicts.size() == 0) begin
            $display("%0t: result with nothing expected: detected %0b calibrated %0b baseline %0d",
                     $time, o_detected, o_calibrated, o_baseline);
            err_count++;
        end else begin
            want = pending_verdicts.pop_front();
            if (o_detected !== want.detected) begin
                $display("%0t: detected expected %0b got %0b", $time, want.detected, o_detected);
                err_count++;
            end
            if (o_calibrated !== want.calibrated) begin
                $display("%0t: calibrated expected %0b got %0b",
                         $time, want.calibrated, o_calibrated);
                err_count++;
            end
            if (o_baseline !== want.baseline) begin
                $display("%0t: baseline expected %0d got %0d", $time, want.baseline, o_baseline);
                err_count++;
            end
        end
    endtask

    // Result side: random stalls, calm stretches, and a long hold every few hundred results.
    always @(posedge i_clk) begin
        int pick;
        if (i_rst_n && o_valid && i_ready) begin
            check_result();
            if (results_seen % HOLD_EVERY == 0) rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            pick = $urandom_range(0, 99);
            if (rx_calm || pick < 60) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_hold = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(20, 80);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int                     r;
        int                     ph;
        int                     k;
        int                     pick;
        int                     v;
        int                     centre;
        t_plan_row              row;
        logic [SAMPLE_BITS-1:0] value;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_plan[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.value[CFG_DATA_W-1:0]);
            end else begin
                offer_sample(row.value, row.typed, row.want);
                sender_pause();
            end
        end

        // Fill the calibration store: a cluster with ties, rail values and uniform noise.
        centre = $urandom_range(40, SAMPLE_MAX - 43);
        while (!calib_done) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                v = centre - 6 + int'($urandom_range(0, 12));
            else if (pick < 40)
                v = pick[0] ? SAMPLE_MAX : 0;
            else
                v = $urandom_range(0, SAMPLE_MAX);
            offer_sample(v[SAMPLE_BITS-1:0], 1'b0, NOT_CALIBRATED);
            sender_pause();
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_reg(CFG_MARGIN, 8'hE4);     // top bit is dropped, leaving 100%
                1: write_reg(CFG_MARGIN, 8'd0);
                2: begin
                    write_reg(CFG_MARGIN, 8'hFF);
                    write_reg(CFG_DISCARD, 8'd255);  // must not disturb a finished calibration
                end
                3: write_reg(CFG_MARGIN, 8'd101);
                5: begin
                    write_reg(CFG_MARGIN, 8'($urandom_range(1, 99)));
                    write_reg(CFG_DISCARD, 8'd0);
                end
                default: write_reg(CFG_MARGIN, 8'($urandom_range(1, 99)));
            endcase
            tx_calm = (ph == 4) || ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    v = drop_level() - 2 + int'($urandom_range(0, 4));
                else if (pick < 55)
                    v = pick[0] ? SAMPLE_MAX : 0;
                else
                    v = $urandom_range(0, SAMPLE_MAX);
                if (v < 0) v = 0;
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                value = v[SAMPLE_BITS-1:0];
                offer_sample(value, 1'b0, NOT_CALIBRATED);
                sender_pause();
            end
        end

        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample items (%0d before the baseline of %0d was set), %0d results checked",
                 items_sent, calib_items, median_q, results_seen);
        $display("with %0d drops flagged; margins 0, 100, 101 and 127 and discard 0 and 255 were used.",
                 drops_seen);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
